### hw/rtl/cafe_pkg.sv
// Shared types, codes and constants of the cursor address format expander.
// Used by cafe_front, cafe_back and the top level; depends on nothing.
package cafe_pkg;

    localparam int OUT_SIZE_DEF  = 80;
    localparam int FIX_DEPTH_DEF = 8;
    localparam int QUEUE_DEPTH   = 4;

    // Input operation codes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_CHAR  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // Register indexes of the configuration port.
    localparam logic [0:0] REG_UP_LEN   = 1'b0;
    localparam logic [0:0] REG_BACK_LEN = 1'b1;

    // Format characters.
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BCD   = 8'h42;
    localparam logic [7:0] CH_CHAR  = 8'h43;
    localparam logic [7:0] CH_DELTA = 8'h44;
    localparam logic [7:0] CH_DEC   = 8'h64;
    localparam logic [7:0] CH_INC   = 8'h69;
    localparam logic [7:0] CH_XMASK = 8'h6D;
    localparam logic [7:0] CH_XORN  = 8'h6E;
    localparam logic [7:0] CH_REV   = 8'h72;

    // Values that a character output must not send as they are.
    localparam logic [15:0] VAL_CTRL_D  = 16'h0004;
    localparam logic [15:0] VAL_NEWLINE = 16'h000A;

    localparam logic [15:0] MASK_M = 16'o177;
    localparam logic [15:0] MASK_N = 16'o140;

    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_UP   = 2'd1,
        K_BACK = 2'd2,
        K_DONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_OVF = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        J_BYTE = 2'd0,
        J_DEC  = 2'd1,
        J_END  = 2'd2
    } t_jkind;

    // One job handed from the parser to the emitter.
    typedef struct packed {
        t_jkind       kind;
        logic [15:0]  data;    // byte in the low bits, or the value to print
        logic [2:0]   ndig;    // decimal digits still to print
        t_status      status;
    } t_job;

endpackage

### hw/rtl/cursor_address_format_expander.sv
// Cursor address format expander, top level.
// Depends on cafe_pkg, cafe_front, cafe_queue and cafe_back.
//
// Usage:
//   Input words arrive on i_valid / o_stall: a start word with column and
//   row, the characters of a cursor-motion format, then an end word. A word
//   is taken when i_valid is high and o_stall is low. Result words leave on
//   o_valid / i_stall; o_last marks the final result caused by one input.
//   The configuration port (i_cfg_valid / o_cfg_ready, always ready) sets
//   the up-line length (index 0) and back-space length (index 1); write it
//   only while the block is idle.
//   Throughput: one input word per cycle while the four-entry job queue has
//   room. Results leave one per cycle unless the receiver stalls, so a
//   decimal code gives one to four results and an end word one per logged
//   fix plus one; the emitter's output register sets this rate. The first
//   result of a word passes the queue and the job and output registers.
//   Reset clears the parser state, the queue and the output register and
//   sets the up-line length to 0 and the back-space length to 1. While the
//   receiver stalls, the output word holds and the queue fills, after which
//   o_stall rises.
module cursor_address_format_expander #(
    parameter int OUT_SIZE  = cafe_pkg::OUT_SIZE_DEF,
    parameter int FIX_DEPTH = cafe_pkg::FIX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_fmt_char,
    input  logic [11:0] i_column,
    input  logic [11:0] i_row,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    localparam int FC_W = $clog2(FIX_DEPTH + 1);
    localparam int JW   = $bits(cafe_pkg::t_job);
    localparam int QW   = JW + FC_W + FIX_DEPTH;

    logic                 accept, push, pop, q_empty, q_full;
    cafe_pkg::t_job       f_job;
    logic [FC_W-1:0]      f_fcnt;
    logic [FIX_DEPTH-1:0] f_flog;
    logic [QW-1:0]        q_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;
    assign accept      = i_valid && !q_full;

    cafe_front #(
        .OUT_SIZE  (OUT_SIZE),
        .FIX_DEPTH (FIX_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_op        (i_op),
        .i_fmt_char  (i_fmt_char),
        .i_column    (i_column),
        .i_row       (i_row),
        .o_push      (push),
        .o_job       (f_job),
        .o_fcnt      (f_fcnt),
        .o_flog      (f_flog)
    );

    cafe_queue #(
        .W     (QW),
        .DEPTH (cafe_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({f_job, f_fcnt, f_flog}),
        .i_pop   (pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cafe_back #(
        .FIX_DEPTH (FIX_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (cafe_pkg::t_job'(q_rdata[QW-1 -: JW])),
        .i_fcnt     (q_rdata[FIX_DEPTH +: FC_W]),
        .i_flog     (q_rdata[FIX_DEPTH-1:0]),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_kind     (o_kind),
        .o_out_byte (o_out_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule

### hw/rtl/cafe_queue.sv
// Short job queue between parser and emitter, register based.
// Generic in width and depth; depends on nothing.
module cafe_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty,
    output logic         o_full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        f_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_rdata = r_mem[r_rptr];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= f_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= f_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

### hw/rtl/cafe_front.sv
// Parser of the expander: holds the format state and the configuration,
// classifies every accepted word and issues jobs. Depends on cafe_pkg.
module cafe_front #(
    parameter int OUT_SIZE  = cafe_pkg::OUT_SIZE_DEF,
    parameter int FIX_DEPTH = cafe_pkg::FIX_DEPTH_DEF,
    localparam int FC_W     = $clog2(FIX_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [3:0]            i_cfg_data,
    input  logic                  i_accept,
    input  logic [1:0]            i_op,
    input  logic [7:0]            i_fmt_char,
    input  logic [11:0]           i_column,
    input  logic [11:0]           i_row,
    output logic                  o_push,
    output cafe_pkg::t_job        o_job,
    output logic [FC_W-1:0]       o_fcnt,
    output logic [FIX_DEPTH-1:0]  o_flog
);
    typedef enum logic [6:0] {
        M_NORMAL  = 7'b0000001,
        M_PERCENT = 7'b0000010,
        M_PLUS    = 7'b0000100,
        M_GT_X    = 7'b0001000,
        M_GT_ADD  = 7'b0010000,
        M_GT_SKIP = 7'b0100000,
        M_ERROR   = 7'b1000000
    } t_mode;

    logic [3:0]           r_up_len, r_back_len;
    t_mode                r_mode, n_mode;
    logic [15:0]          r_cur, n_cur, r_col, n_col, r_row, n_row;
    logic                 r_use_col, n_use_col;
    logic [6:0]           r_out_cnt, n_out_cnt;
    logic [FIX_DEPTH-1:0] r_flog, n_flog;
    logic [FC_W-1:0]      r_fcnt, n_fcnt;
    logic [7:0]           r_flen, n_flen;
    cafe_pkg::t_status    r_err, n_err;

    // One shared reciprocal multiplier: divide by 10 for the BCD code and
    // by 96 (a shift by five, then divide by 3) for the character code.
    logic        sel_ten;
    logic [15:0] mul_a, mul_k, quo;
    logic [31:0] prod;
    logic [15:0] rem96;

    assign sel_ten = (i_fmt_char == cafe_pkg::CH_BCD);
    assign mul_a   = sel_ten ? r_cur : {5'b0, r_cur[15:5]};
    assign mul_k   = sel_ten ? 16'd52429 : 16'd43691;
    assign prod    = mul_a * mul_k;
    assign quo     = sel_ten ? 16'(prod >> 19) : 16'(prod >> 17);
    assign rem96   = r_cur - ((quo << 6) + (quo << 5));

    logic                 do_char, bump;
    logic [15:0]          cv, bv;
    logic [2:0]           add_cnt;
    logic [7:0]           sum_cnt;
    logic [7:0]           fix_len;
    logic [8:0]           end_sum;
    cafe_pkg::t_status    st;

    always_comb begin
        n_mode    = r_mode;
        n_cur     = r_cur;
        n_col     = r_col;
        n_row     = r_row;
        n_use_col = r_use_col;
        n_out_cnt = r_out_cnt;
        n_flog    = r_flog;
        n_fcnt    = r_fcnt;
        n_flen    = r_flen;
        n_err     = r_err;
        o_push    = 1'b0;
        o_job     = '{kind: cafe_pkg::J_BYTE, data: 16'd0, ndig: 3'd0,
                      status: cafe_pkg::ST_OK};
        o_fcnt    = '0;
        do_char   = 1'b0;
        cv        = r_cur;
        bv        = r_cur;
        bump      = 1'b0;
        add_cnt   = 3'd0;
        st        = r_err;
        end_sum   = {2'b0, r_out_cnt} + {1'b0, r_flen};
        fix_len   = r_use_col ? {4'b0, ((r_back_len == 4'd0) ? 4'd1 : r_back_len)}
                              : {4'b0, r_up_len};

        if (i_accept) begin
            unique case (i_op)
                cafe_pkg::OP_START: begin
                    n_mode    = M_NORMAL;
                    n_use_col = 1'b0;
                    n_out_cnt = '0;
                    n_fcnt    = '0;
                    n_flen    = '0;
                    n_err     = cafe_pkg::ST_OK;
                    n_col     = {4'b0, i_column};
                    n_row     = {4'b0, i_row};
                    n_cur     = {4'b0, i_row};
                end
                cafe_pkg::OP_CHAR: begin
                    unique case (r_mode)
                        M_NORMAL: begin
                            if ({1'b0, r_out_cnt} + 8'd5 >= 8'(OUT_SIZE)) begin
                                n_mode = M_ERROR;
                                n_err  = cafe_pkg::ST_OVF;
                            end else if (i_fmt_char == cafe_pkg::CH_PCT) begin
                                n_mode = M_PERCENT;
                            end else begin
                                o_push    = 1'b1;
                                o_job.data = {8'b0, i_fmt_char};
                                add_cnt   = 3'd1;
                            end
                        end
                        M_PERCENT: begin
                            n_mode = M_NORMAL;
                            unique case (i_fmt_char)
                                cafe_pkg::CH_PCT: begin
                                    o_push     = 1'b1;
                                    o_job.data = {8'b0, cafe_pkg::CH_PCT};
                                    add_cnt    = 3'd1;
                                end
                                cafe_pkg::CH_DEC, cafe_pkg::CH_TWO,
                                cafe_pkg::CH_THREE: begin
                                    o_push     = 1'b1;
                                    o_job.kind = cafe_pkg::J_DEC;
                                    o_job.data = r_cur;
                                    if (i_fmt_char == cafe_pkg::CH_TWO) begin
                                        o_job.ndig = 3'd2;
                                    end else if (i_fmt_char == cafe_pkg::CH_DEC
                                                 && r_cur < 16'd10) begin
                                        o_job.ndig = 3'd1;
                                    end else if (i_fmt_char == cafe_pkg::CH_DEC
                                                 && r_cur < 16'd100) begin
                                        o_job.ndig = 3'd2;
                                    end else if (r_cur >= 16'd1000) begin
                                        o_job.ndig = 3'd4;
                                    end else begin
                                        o_job.ndig = 3'd3;
                                    end
                                    add_cnt   = o_job.ndig;
                                    n_use_col = ~r_use_col;
                                    n_cur     = r_use_col ? r_row : r_col;
                                end
                                cafe_pkg::CH_CHAR: begin
                                    if (r_cur >= 16'd96) begin
                                        o_push     = 1'b1;
                                        o_job.data = {8'b0, quo[7:0]};
                                        add_cnt    = 3'd1;
                                        n_cur      = rem96;
                                    end
                                    n_mode = M_PLUS;
                                end
                                cafe_pkg::CH_PLUS: n_mode = M_PLUS;
                                cafe_pkg::CH_DOT:  do_char = 1'b1;
                                cafe_pkg::CH_GT:   n_mode = M_GT_X;
                                cafe_pkg::CH_BCD: begin
                                    n_cur = r_cur + (quo << 2) + (quo << 1);
                                end
                                cafe_pkg::CH_DELTA: begin
                                    n_cur = r_cur - {11'b0, r_cur[3:0], 1'b0};
                                end
                                cafe_pkg::CH_INC: begin
                                    n_col = r_col + 16'd1;
                                    n_row = r_row + 16'd1;
                                    n_cur = r_cur + 16'd1;
                                end
                                cafe_pkg::CH_XMASK: begin
                                    n_col = r_col ^ cafe_pkg::MASK_M;
                                    n_row = r_row ^ cafe_pkg::MASK_M;
                                    n_cur = r_use_col ? n_col : n_row;
                                end
                                cafe_pkg::CH_XORN: begin
                                    n_col = r_col ^ cafe_pkg::MASK_N;
                                    n_row = r_row ^ cafe_pkg::MASK_N;
                                    n_cur = r_use_col ? n_col : n_row;
                                end
                                cafe_pkg::CH_REV: begin
                                    n_use_col = 1'b1;
                                    n_cur     = r_col;
                                end
                                default: begin
                                    n_mode = M_ERROR;
                                    n_err  = cafe_pkg::ST_BAD;
                                end
                            endcase
                        end
                        M_PLUS: begin
                            n_mode  = M_NORMAL;
                            cv      = r_cur + {8'b0, i_fmt_char};
                            n_cur   = cv;
                            do_char = 1'b1;
                        end
                        M_GT_X: begin
                            n_mode = (r_cur > {8'b0, i_fmt_char}) ? M_GT_ADD : M_GT_SKIP;
                        end
                        M_GT_ADD: begin
                            n_mode = M_NORMAL;
                            n_cur  = r_cur + {8'b0, i_fmt_char};
                        end
                        M_GT_SKIP: n_mode = M_NORMAL;
                        M_ERROR: ;
                        default: ;
                    endcase
                end
                cafe_pkg::OP_END: begin
                    if (r_err == cafe_pkg::ST_OK && r_mode != M_NORMAL) begin
                        st = cafe_pkg::ST_BAD;
                    end
                    if (st == cafe_pkg::ST_OK && end_sum >= 9'(OUT_SIZE)) begin
                        st = cafe_pkg::ST_OVF;
                    end
                    o_push       = 1'b1;
                    o_job.kind   = cafe_pkg::J_END;
                    o_job.status = st;
                    o_fcnt       = (st == cafe_pkg::ST_OK) ? r_fcnt : '0;
                    n_mode       = M_NORMAL;
                    n_cur        = '0;
                    n_col        = '0;
                    n_row        = '0;
                    n_use_col    = 1'b0;
                    n_out_cnt    = '0;
                    n_fcnt       = '0;
                    n_flen       = '0;
                    n_err        = cafe_pkg::ST_OK;
                end
                default: ;
            endcase
        end

        // Character output: values that a terminal would swallow are bumped
        // by one and a cursor fix is logged for the end of the string.
        if (do_char) begin
            bump = (r_use_col || r_up_len != 4'd0)
                && (cv == 16'd0 || cv == cafe_pkg::VAL_CTRL_D
                    || cv == cafe_pkg::VAL_NEWLINE);
            if (bump && r_fcnt >= FC_W'(FIX_DEPTH)) begin
                n_mode = M_ERROR;
                n_err  = cafe_pkg::ST_OVF;
            end else begin
                if (bump) begin
                    for (int i = 0; i < FIX_DEPTH; i++) begin
                        if (r_fcnt == FC_W'(i)) begin
                            n_flog[i] = r_use_col;
                        end
                    end
                    n_fcnt = r_fcnt + 1'b1;
                    n_flen = r_flen + fix_len;
                end
                bv         = cv + {15'b0, bump};
                o_push     = 1'b1;
                o_job.data = {8'b0, bv[7:0]};
                add_cnt    = 3'd1;
                n_use_col  = ~r_use_col;
                n_cur      = r_use_col ? r_row : r_col;
            end
        end

        // The output count saturates at its top value.
        sum_cnt = {1'b0, r_out_cnt} + {5'b0, add_cnt};
        if (add_cnt != 3'd0) begin
            n_out_cnt = sum_cnt[7] ? 7'd127 : sum_cnt[6:0];
        end
    end

    assign o_flog = r_flog;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_len   <= 4'd0;
            r_back_len <= 4'd1;
            r_mode     <= M_NORMAL;
            r_cur      <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_use_col  <= 1'b0;
            r_out_cnt  <= '0;
            r_fcnt     <= '0;
            r_flen     <= '0;
            r_err      <= cafe_pkg::ST_OK;
        end else begin
            if (i_cfg_we && i_cfg_index == cafe_pkg::REG_UP_LEN) begin
                r_up_len <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == cafe_pkg::REG_BACK_LEN) begin
                r_back_len <= i_cfg_data;
            end
            r_mode    <= n_mode;
            r_cur     <= n_cur;
            r_col     <= n_col;
            r_row     <= n_row;
            r_use_col <= n_use_col;
            r_out_cnt <= n_out_cnt;
            r_fcnt    <= n_fcnt;
            r_flen    <= n_flen;
            r_err     <= n_err;
        end
    end

    // The fix log is only read below the fix count, so it needs no reset.
    always_ff @(posedge i_clk) begin
        r_flog <= n_flog;
    end

endmodule

### hw/rtl/cafe_back.sv
// Emitter (depends on cafe_pkg): takes jobs from the queue and, when not
// stalled, sends one result word a cycle through an output register.
module cafe_back #(
    parameter int FIX_DEPTH = cafe_pkg::FIX_DEPTH_DEF,
    localparam int FC_W     = $clog2(FIX_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cafe_pkg::t_job        i_job,
    input  logic [FC_W-1:0]       i_fcnt,
    input  logic [FIX_DEPTH-1:0]  i_flog,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_out_byte,
    output logic [1:0]            o_status,
    output logic                  o_last
);
    logic                 r_have;
    cafe_pkg::t_job       r_job, n_job;
    logic [FC_W-1:0]      r_fcnt, n_fcnt;
    logic [FIX_DEPTH-1:0] r_flog, n_flog;

    logic                 r_valid, r_last;
    cafe_pkg::t_kind      r_kind, res_kind;
    logic [7:0]           r_byte, res_byte;
    cafe_pkg::t_status    r_status, res_status;
    logic                 res_last;

    logic                 load_ok, step, fin;

    // Leading decimal digit by reciprocal multiplication; the remainder is
    // taken with shift-and-add forms of 1000, 100 and 10.
    logic [16:0] dk;
    logic [32:0] dprod;
    logic [15:0] dq, dqd;

    always_comb begin
        unique case (r_job.ndig)
            3'd4:    dk = 17'd67109;
            3'd3:    dk = 17'd5243;
            default: dk = 17'd52429;
        endcase
        dprod = {17'b0, r_job.data} * {16'b0, dk};
        unique case (r_job.ndig)
            3'd4: begin
                dq  = 16'(dprod >> 26);
                dqd = (dq << 10) - (dq << 4) - (dq << 3);
            end
            3'd3: begin
                dq  = 16'(dprod >> 19);
                dqd = (dq << 6) + (dq << 5) + (dq << 2);
            end
            default: begin
                dq  = 16'(dprod >> 19);
                dqd = (dq << 3) + (dq << 1);
            end
        endcase
    end

    always_comb begin
        n_job      = r_job;
        n_fcnt     = r_fcnt;
        n_flog     = r_flog;
        res_kind   = cafe_pkg::K_BYTE;
        res_byte   = 8'd0;
        res_status = cafe_pkg::ST_OK;
        res_last   = 1'b1;
        unique case (r_job.kind)
            cafe_pkg::J_BYTE: begin
                res_byte = r_job.data[7:0];
            end
            cafe_pkg::J_DEC: begin
                if (r_job.ndig <= 3'd1) begin
                    res_byte = cafe_pkg::CH_ZERO + r_job.data[7:0];
                end else begin
                    res_byte   = cafe_pkg::CH_ZERO + dq[7:0];
                    res_last   = 1'b0;
                    n_job.data = r_job.data - dqd;
                    n_job.ndig = r_job.ndig - 3'd1;
                end
            end
            cafe_pkg::J_END: begin
                if (r_fcnt != '0) begin
                    res_kind = r_flog[0] ? cafe_pkg::K_BACK : cafe_pkg::K_UP;
                    res_last = 1'b0;
                    n_flog   = r_flog >> 1;
                    n_fcnt   = r_fcnt - 1'b1;
                end else begin
                    res_kind   = cafe_pkg::K_DONE;
                    res_status = r_job.status;
                end
            end
            default: ;
        endcase
    end

    assign load_ok = !r_valid || !i_stall;
    assign step    = r_have && load_ok;
    assign fin     = step && res_last;
    assign o_pop   = (!r_have || fin) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have <= 1'b1;
            end else if (fin) begin
                r_have <= 1'b0;
            end
            if (load_ok) begin
                r_valid <= step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_fcnt <= i_fcnt;
            r_flog <= i_flog;
        end else if (step) begin
            r_job  <= n_job;
            r_fcnt <= n_fcnt;
            r_flog <= n_flog;
        end
        if (step) begin
            r_kind   <= res_kind;
            r_byte   <= res_byte;
            r_status <= res_status;
            r_last   <= res_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_out_byte = r_byte;
    assign o_status   = r_status;
    assign o_last     = r_last;

endmodule
